>>> hw/rtl/sac_plru_pkg.sv
// Shared constants, types and replacement-policy tables for the 4-way PLRU cache tag block.
// Used by the datapath, controller, top level and checker by scoped names.
`default_nettype none

package sac_plru_pkg;

    localparam int SET_COUNT   = 8;   // power of two, 2..256
    localparam int OFFSET_BITS = 4;   // 2..8
    localparam int WAY_COUNT   = 4;
    localparam int WAY_W       = 2;
    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 32;
    localparam int PLRU_W      = 3;
    localparam int INDEX_W     = $clog2(SET_COUNT);
    localparam int TAG_W       = ADDR_W - OFFSET_BITS - INDEX_W;
    localparam int ROW_W       = WAY_COUNT * TAG_W;

    // access kind on the op field
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [PLRU_W-1:0] plru_t;
    typedef logic [WAY_W-1:0]  way_t;

    // next tree state, indexed by [low two state bits][accessed way]
    localparam plru_t PLRU_NEXT [4][4] = '{
        '{3'd6, 3'd4, 3'd1, 3'd0},
        '{3'd7, 3'd5, 3'd1, 3'd0},
        '{3'd6, 3'd4, 3'd3, 3'd2},
        '{3'd7, 3'd5, 3'd3, 3'd2}
    };

    // victim way, indexed by the full tree state
    localparam way_t PLRU_VICTIM [8] = '{
        2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
    };

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming transaction, start the tag row read
        logic commit;    // resolve the lookup, update state and load the result
    } sac_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/sac_plru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sac_plru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sac_plru_dp.sv
// Datapath: tag RAM, per-set valid/dirty/PLRU state, hit and victim logic, counters.
// Depends on sac_plru_pkg and sac_plru_ram.
`default_nettype none

module sac_plru_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire sac_plru_pkg::sac_cmd_t             cmd,
    input  wire logic                               op,
    input  wire logic [sac_plru_pkg::ADDR_W-1:0]    address,
    output logic                                    hit,
    output logic [sac_plru_pkg::WAY_W-1:0]          way,
    output logic                                    write_back,
    output logic [sac_plru_pkg::CNT_W-1:0]          read_total,
    output logic [sac_plru_pkg::CNT_W-1:0]          write_total,
    output logic [sac_plru_pkg::CNT_W-1:0]          hit_total,
    output logic [sac_plru_pkg::CNT_W-1:0]          miss_total,
    output logic [sac_plru_pkg::CNT_W-1:0]          write_back_total
);

    // latched transaction
    logic                              op_reg;
    logic [sac_plru_pkg::INDEX_W-1:0]  set_reg;
    logic [sac_plru_pkg::TAG_W-1:0]    tag_reg;

    // per-set state in flops, cleared at reset
    logic [sac_plru_pkg::WAY_COUNT-1:0] valid_reg [sac_plru_pkg::SET_COUNT];
    logic [sac_plru_pkg::WAY_COUNT-1:0] dirty_reg [sac_plru_pkg::SET_COUNT];
    sac_plru_pkg::plru_t                plru_reg  [sac_plru_pkg::SET_COUNT];

    // result and counters
    logic                              hit_reg;
    sac_plru_pkg::way_t                way_reg;
    logic                              wb_reg;
    logic [sac_plru_pkg::CNT_W-1:0]    read_cnt_reg;
    logic [sac_plru_pkg::CNT_W-1:0]    write_cnt_reg;
    logic [sac_plru_pkg::CNT_W-1:0]    hit_cnt_reg;
    logic [sac_plru_pkg::CNT_W-1:0]    miss_cnt_reg;
    logic [sac_plru_pkg::CNT_W-1:0]    wb_cnt_reg;

    // tag RAM: one row per set, all four ways side by side
    logic [sac_plru_pkg::ROW_W-1:0]    row_rdata;
    logic [sac_plru_pkg::ROW_W-1:0]    row_wdata;
    logic                              row_we;
    logic [sac_plru_pkg::INDEX_W-1:0]  rd_set;

    // lookup
    logic [sac_plru_pkg::WAY_COUNT-1:0] valid_row;
    logic [sac_plru_pkg::WAY_COUNT-1:0] dirty_row;
    sac_plru_pkg::plru_t                plru_row;
    logic [sac_plru_pkg::WAY_COUNT-1:0] hit_vec;
    logic                               lk_hit;
    sac_plru_pkg::way_t                 hit_way;
    sac_plru_pkg::way_t                 free_way;
    sac_plru_pkg::way_t                 acc_way;
    logic                               lk_wb;
    logic [sac_plru_pkg::WAY_COUNT-1:0] way_mask;
    logic [sac_plru_pkg::WAY_COUNT-1:0] valid_next;
    logic [sac_plru_pkg::WAY_COUNT-1:0] dirty_next;
    sac_plru_pkg::plru_t                plru_next;

    assign rd_set = address[sac_plru_pkg::OFFSET_BITS +: sac_plru_pkg::INDEX_W];

    sac_plru_ram #(
        .WIDTH (sac_plru_pkg::ROW_W),
        .DEPTH (sac_plru_pkg::SET_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (set_reg),
        .wdata (row_wdata),
        .re    (cmd.capture),
        .raddr (rd_set),
        .rdata (row_rdata)
    );

    always_comb
    begin
        valid_row = valid_reg[set_reg];
        dirty_row = dirty_reg[set_reg];
        plru_row  = plru_reg[set_reg];

        for (int w = 0; w < sac_plru_pkg::WAY_COUNT; w++)
        begin
            hit_vec[w] = valid_row[w] &&
                (row_rdata[w*sac_plru_pkg::TAG_W +: sac_plru_pkg::TAG_W] == tag_reg);
        end

        // lowest matching way wins
        hit_way = '0;
        for (int w = sac_plru_pkg::WAY_COUNT - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = sac_plru_pkg::WAY_W'(w);
            end
        end
        lk_hit = |hit_vec;

        // lowest invalid way, or the tree victim when the set is full
        free_way = sac_plru_pkg::PLRU_VICTIM[plru_row];
        for (int w = sac_plru_pkg::WAY_COUNT - 1; w >= 0; w--)
        begin
            if (!valid_row[w])
            begin
                free_way = sac_plru_pkg::WAY_W'(w);
            end
        end

        acc_way  = lk_hit ? hit_way : free_way;
        way_mask = '0;
        way_mask[acc_way] = 1'b1;

        lk_wb = !lk_hit && valid_row[acc_way] && dirty_row[acc_way];

        valid_next = valid_row | way_mask;
        dirty_next = lk_hit ? dirty_row : (dirty_row & ~way_mask);
        if (op_reg == sac_plru_pkg::OP_WRITE)
        begin
            dirty_next = dirty_next | way_mask;
        end
        plru_next = sac_plru_pkg::PLRU_NEXT[plru_row[1:0]][acc_way];

        // replace the victim's tag, keep the other ways
        for (int w = 0; w < sac_plru_pkg::WAY_COUNT; w++)
        begin
            row_wdata[w*sac_plru_pkg::TAG_W +: sac_plru_pkg::TAG_W] =
                (sac_plru_pkg::WAY_W'(w) == acc_way) ? tag_reg
                : row_rdata[w*sac_plru_pkg::TAG_W +: sac_plru_pkg::TAG_W];
        end
        row_we = cmd.commit && !lk_hit;
    end

    // transaction capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            set_reg <= rd_set;
            tag_reg <= address[sac_plru_pkg::ADDR_W-1 -: sac_plru_pkg::TAG_W];
        end
        if (cmd.commit)
        begin
            hit_reg <= lk_hit;
            way_reg <= acc_way;
            wb_reg  <= lk_wb;
        end
    end

    // set state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < sac_plru_pkg::SET_COUNT; s++)
            begin
                valid_reg[s] <= '0;
                dirty_reg[s] <= '0;
                plru_reg[s]  <= '0;
            end
            read_cnt_reg  <= '0;
            write_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            wb_cnt_reg    <= '0;
        end
        else if (cmd.commit)
        begin
            valid_reg[set_reg] <= valid_next;
            dirty_reg[set_reg] <= dirty_next;
            plru_reg[set_reg]  <= plru_next;
            if (op_reg == sac_plru_pkg::OP_WRITE)
            begin
                write_cnt_reg <= write_cnt_reg + sac_plru_pkg::CNT_W'(1);
            end
            else
            begin
                read_cnt_reg <= read_cnt_reg + sac_plru_pkg::CNT_W'(1);
            end
            if (lk_hit)
            begin
                hit_cnt_reg <= hit_cnt_reg + sac_plru_pkg::CNT_W'(1);
            end
            else
            begin
                miss_cnt_reg <= miss_cnt_reg + sac_plru_pkg::CNT_W'(1);
            end
            if (lk_wb)
            begin
                wb_cnt_reg <= wb_cnt_reg + sac_plru_pkg::CNT_W'(1);
            end
        end
    end

    assign hit              = hit_reg;
    assign way              = way_reg;
    assign write_back       = wb_reg;
    assign read_total       = read_cnt_reg;
    assign write_total      = write_cnt_reg;
    assign hit_total        = hit_cnt_reg;
    assign miss_total       = miss_cnt_reg;
    assign write_back_total = wb_cnt_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sac_plru_ctrl.sv
// Controller: sequences capture, lookup and result hand-off for one transaction at a time.
// Depends on sac_plru_pkg.
`default_nettype none

module sac_plru_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output sac_plru_pkg::sac_cmd_t      cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // the result register may be reloaded once its transaction leaves
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/set_assoc_cache_tag_plru.sv
// Top level of the 4-way set-associative cache tag and tree-PLRU block.
// Depends on sac_plru_pkg, sac_plru_ctrl and sac_plru_dp.
//
// Usage:
//   Input channel (in_valid/in_ready, op, address) carries one access per
//   transaction: op is read or write, address a byte address. Output channel
//   (out_valid/out_ready) returns exactly one result per access: hit, way,
//   write_back and the five running totals, this access included.
//   An accepted transaction is captured and its tag row read into the RAM's
//   registered output; the compare-and-update step of the same set then
//   loads the result register, once that register is free.
//   One access is in flight at a time; in_ready is high only when idle.
//   A waiting result sits in the output register, so the next access is
//   accepted and its tag row read while the receiver stalls; only its
//   update step holds until the output register is free.
//   Reset clears all valid, dirty and PLRU bits and the counters at once
//   (flops, no clearing pass); the tag RAM contents need no reset since a
//   tag is only compared for a valid way.
`default_nettype none

module set_assoc_cache_tag_plru (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               op,
    input  wire logic [sac_plru_pkg::ADDR_W-1:0]    address,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    hit,
    output logic [sac_plru_pkg::WAY_W-1:0]          way,
    output logic                                    write_back,
    output logic [sac_plru_pkg::CNT_W-1:0]          read_total,
    output logic [sac_plru_pkg::CNT_W-1:0]          write_total,
    output logic [sac_plru_pkg::CNT_W-1:0]          hit_total,
    output logic [sac_plru_pkg::CNT_W-1:0]          miss_total,
    output logic [sac_plru_pkg::CNT_W-1:0]          write_back_total
);

    sac_plru_pkg::sac_cmd_t cmd;

    // sequence capture and commit, own both handshakes
    sac_plru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // hold tags and set state, resolve hit or victim, advance counters
    sac_plru_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .op               (op),
        .address          (address),
        .hit              (hit),
        .way              (way),
        .write_back       (write_back),
        .read_total       (read_total),
        .write_total      (write_total),
        .hit_total        (hit_total),
        .miss_total       (miss_total),
        .write_back_total (write_back_total)
    );

endmodule

`default_nettype wire

>>> hw/rtl/sac_plru_checker.sv
// Port-level checker for the cache tag block, bound to the top level.
// Depends on sac_plru_pkg.
`default_nettype none

module sac_plru_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic                               hit,
    input  wire logic [sac_plru_pkg::WAY_W-1:0]     way,
    input  wire logic                               write_back,
    input  wire logic [sac_plru_pkg::CNT_W-1:0]     read_total,
    input  wire logic [sac_plru_pkg::CNT_W-1:0]     write_total,
    input  wire logic [sac_plru_pkg::CNT_W-1:0]     hit_total,
    input  wire logic [sac_plru_pkg::CNT_W-1:0]     miss_total
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(way)
            && $stable(write_back))
        else $error("stalled result changed");

    // one access in flight: an accepted transaction drops in_ready
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted while busy");

    // a hit never evicts
    a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !write_back)
        else $error("write-back flagged on a hit");

    // every access is counted once as read or write and once as hit or miss
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        sac_plru_pkg::CNT_W'(read_total + write_total)
            == sac_plru_pkg::CNT_W'(hit_total + miss_total))
        else $error("access totals disagree");

endmodule

bind set_assoc_cache_tag_plru sac_plru_checker u_sac_plru_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .way         (way),
    .write_back  (write_back),
    .read_total  (read_total),
    .write_total (write_total),
    .hit_total   (hit_total),
    .miss_total  (miss_total)
);

`default_nettype wire
